// ===== rtl/sensor_poll_coordinator_assert.svh =====
// ----------------------------------------------------------------------------
// sensor poll coordinator assertion macros
// shared property forms for the coordinator checks
// ----------------------------------------------------------------------------
`ifndef SENSOR_POLL_COORDINATOR_ASSERT_SVH
`define SENSOR_POLL_COORDINATOR_ASSERT_SVH

// same-cycle implication
`define SPC_ASSERT_IMPLY(lbl, clk, rst, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("spc same-cycle check failed");

// next-cycle implication
`define SPC_ASSERT_NEXT(lbl, clk, rst, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("spc next-cycle check failed");

`endif

// ===== rtl/spc_pkg.sv =====
// ----------------------------------------------------------------------------
// spc_pkg
// constants, codes and result type of the sensor poll coordinator
// ----------------------------------------------------------------------------
package spc_pkg;

  localparam int MAX_NODES = 8;
  localparam int IDX_W     = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int CNT_W     = $clog2(MAX_NODES + 1);
  localparam int ADDR_W    = 16;
  localparam int TEMP_W    = 16;
  localparam int BYTE_W    = 8;
  localparam int MODE_W    = 2;
  localparam int KIND_W    = 2;
  localparam int SKIND_W   = 2;
  localparam int DEV_W     = 3;
  localparam int DCNT_W    = 4;

  // work modes
  localparam logic [MODE_W-1:0] MODE_SYNC = 2'd0;
  localparam logic [MODE_W-1:0] MODE_DATA = 2'd1;

  // operations
  localparam logic OP_TICK   = 1'b0;
  localparam logic OP_PACKET = 1'b1;

  // received packet kinds
  localparam logic [KIND_W-1:0] PK_NODE_RESP = 2'd0;
  localparam logic [KIND_W-1:0] PK_STARTED   = 2'd1;
  localparam logic [KIND_W-1:0] PK_DATA_RESP = 2'd2;

  // send request kinds
  localparam logic [SKIND_W-1:0] SK_BROADCAST = 2'd0;
  localparam logic [SKIND_W-1:0] SK_DATA      = 2'd1;
  localparam logic [SKIND_W-1:0] SK_START     = 2'd2;

  typedef struct packed {
    logic               send_valid;
    logic [SKIND_W-1:0] send_kind;
    logic [ADDR_W-1:0]  dest_addr;
    logic               temp_valid;
    logic [DEV_W-1:0]   device_index;
    logic [TEMP_W-1:0]  temperature;
    logic [DCNT_W-1:0]  device_count;
    logic               all_ready;
  } spc_result_t;

endpackage

// ===== rtl/spc_in_if.sv =====
// ----------------------------------------------------------------------------
// spc_in_if
// input channel: send ticks and received packets
// ----------------------------------------------------------------------------
interface spc_in_if;
  logic                        valid;
  logic                        ready;
  logic                        operation;
  logic [spc_pkg::ADDR_W-1:0]  src_addr;
  logic [spc_pkg::KIND_W-1:0]  packet_kind;
  logic [spc_pkg::BYTE_W-1:0]  payload_high;
  logic [spc_pkg::BYTE_W-1:0]  payload_low;

  modport source (output valid, operation, src_addr, packet_kind, payload_high,
                  payload_low, input ready);
  modport sink (input valid, operation, src_addr, packet_kind, payload_high,
                payload_low, output ready);
endinterface

// ===== rtl/spc_out_if.sv =====
// ----------------------------------------------------------------------------
// spc_out_if
// result channel: send requests, stored temperatures and table status
// ----------------------------------------------------------------------------
interface spc_out_if;
  logic                         valid;
  logic                         ready;
  logic                         send_valid;
  logic [spc_pkg::SKIND_W-1:0]  send_kind;
  logic [spc_pkg::ADDR_W-1:0]   dest_addr;
  logic                         temp_valid;
  logic [spc_pkg::DEV_W-1:0]    device_index;
  logic [spc_pkg::TEMP_W-1:0]   temperature;
  logic [spc_pkg::DCNT_W-1:0]   device_count;
  logic                         all_ready;

  modport source (output valid, send_valid, send_kind, dest_addr, temp_valid,
                  device_index, temperature, device_count, all_ready,
                  input ready);
  modport sink (input valid, send_valid, send_kind, dest_addr, temp_valid,
                device_index, temperature, device_count, all_ready,
                output ready);
endinterface

// ===== rtl/spc_addr_ram.sv =====
// ----------------------------------------------------------------------------
// spc_addr_ram
// simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module spc_addr_ram #(
  parameter int DEPTH = 8,
  parameter int WIDTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/sensor_poll_coordinator.sv =====
// flow: a broadcast or ignored word goes from accept to the output stage, a poll
//   reads its target first, a received packet scans one table entry per cycle first
// one word at a time: a new word is accepted only back in idle, so the serial address
//   scan through the single read port of the address ram and a full output hold it up
// reset: synchronous, active high; clears mode, node count, poll pointer,
//   ready bits and all-ready flag; no clearing pass, the node count fences reads
// ----------------------------------------------------------------------------
// sensor_poll_coordinator
// keeps a table of sensor node addresses and polls them round-robin
// ----------------------------------------------------------------------------
module sensor_poll_coordinator (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wr_en,
  input  logic [spc_pkg::MODE_W-1:0]  cfg_wr_data,
  spc_in_if.sink                      in_ch,
  spc_out_if.source                   out_ch
);

  localparam int IDX_W  = spc_pkg::IDX_W;
  localparam int CNT_W  = spc_pkg::CNT_W;
  localparam int NODES  = spc_pkg::MAX_NODES;

  typedef enum logic [1:0] {
    S_IDLE,
    S_POLL,
    S_SCAN,
    S_OUT
  } state_t;

  state_t state;

  // configuration
  logic [spc_pkg::MODE_W-1:0] run_mode;

  // latched input word
  logic                        in_op;
  logic [spc_pkg::ADDR_W-1:0]  in_src;
  logic [spc_pkg::KIND_W-1:0]  in_kind;
  logic [spc_pkg::TEMP_W-1:0]  in_temp;

  // table state outside the address ram
  logic [CNT_W-1:0]  count;
  logic [IDX_W-1:0]  poll_index;
  logic              everyone_ready;
  logic [NODES-1:0]  node_ready;

  // scan pointer: index of the entry now on the ram read port
  logic [IDX_W-1:0]  scan_idx;

  // result staging and output register
  spc_pkg::spc_result_t pend;
  spc_pkg::spc_result_t pend_base;
  spc_pkg::spc_result_t out_res;
  logic                 out_valid;

  // address ram port signals
  logic                        ram_we;
  logic [IDX_W-1:0]            ram_waddr;
  logic [IDX_W-1:0]            ram_raddr;
  logic [spc_pkg::ADDR_W-1:0]  ram_rdata;

  logic              in_acc;
  logic [CNT_W-1:0]  scan_nxt;
  logic              hit;
  logic              last;
  logic              scan_done;
  logic [NODES-1:0]  reg_mask;
  logic [NODES-1:0]  ready_set;
  logic              all_set;
  logic [CNT_W-1:0]  poll_inc;
  logic [IDX_W-1:0]  poll_next;
  logic              table_room;
  logic              scan_wanted;

  spc_addr_ram #(
    .DEPTH (NODES),
    .WIDTH (spc_pkg::ADDR_W),
    .AW    (IDX_W)
  ) u_addr_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_src),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // accept only from idle; a finished word may still sit in the output register
  assign in_ch.ready = (state == S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;

  // packets that need a table lookup
  assign scan_wanted = (in_ch.operation == spc_pkg::OP_PACKET) &&
                       (((run_mode == spc_pkg::MODE_SYNC) &&
                         (in_ch.packet_kind == spc_pkg::PK_NODE_RESP)) ||
                        ((run_mode == spc_pkg::MODE_DATA) &&
                         ((in_ch.packet_kind == spc_pkg::PK_STARTED) ||
                          (in_ch.packet_kind == spc_pkg::PK_DATA_RESP))));

  // lookup compares registered entries only, first match wins
  assign scan_nxt  = CNT_W'(scan_idx) + CNT_W'(1);
  assign hit       = (count != '0) && (ram_rdata == in_src);
  assign last      = (scan_nxt >= count);
  assign scan_done = (state == S_SCAN) && (hit || last);

  assign table_room = (count < CNT_W'(NODES));

  // read address: poll target or first entry at accept, then next entry
  always_comb begin
    if (state == S_IDLE) begin
      if ((run_mode == spc_pkg::MODE_DATA) && (in_ch.operation == spc_pkg::OP_TICK)) begin
        ram_raddr = poll_index;
      end else begin
        ram_raddr = '0;
      end
    end else begin
      ram_raddr = scan_nxt[IDX_W-1:0];
    end
  end

  // new node goes to the next free slot
  assign ram_we    = scan_done && (run_mode == spc_pkg::MODE_SYNC) && !hit && table_room;
  assign ram_waddr = count[IDX_W-1:0];

  // ready check over registered entries with the matched one set
  always_comb begin
    for (int i = 0; i < NODES; i++) begin
      reg_mask[i]  = (CNT_W'(i) < count);
      ready_set[i] = node_ready[i] | (IDX_W'(i) == scan_idx);
    end
  end
  assign all_set = &(ready_set | ~reg_mask);

  // round-robin pointer wraps at the node count
  assign poll_inc  = CNT_W'(poll_index) + CNT_W'(1);
  assign poll_next = (poll_inc >= count) ? '0 : poll_inc[IDX_W-1:0];

  // fields that every result carries, plus the broadcast request of a sync tick
  always_comb begin
    pend_base              = '0;
    pend_base.device_count = spc_pkg::DCNT_W'(count);
    pend_base.all_ready    = everyone_ready;
    if ((in_ch.operation == spc_pkg::OP_TICK) && (run_mode == spc_pkg::MODE_SYNC)) begin
      pend_base.send_valid = 1'b1;
      pend_base.send_kind  = spc_pkg::SK_BROADCAST;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      run_mode       <= spc_pkg::MODE_SYNC;
      count          <= '0;
      poll_index     <= '0;
      everyone_ready <= 1'b0;
      node_ready     <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        run_mode <= cfg_wr_data;
      end
      // a word moving in from staging keeps the output register full
      if (out_valid && out_ch.ready && (state != S_OUT)) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            in_op    <= in_ch.operation;
            in_src   <= in_ch.src_addr;
            in_kind  <= in_ch.packet_kind;
            in_temp  <= {in_ch.payload_high, in_ch.payload_low};
            pend     <= pend_base;
            scan_idx <= '0;
            priority if ((in_ch.operation == spc_pkg::OP_TICK) &&
                         (run_mode == spc_pkg::MODE_SYNC)) begin
              // broadcast request, already in the staged word
              state <= S_OUT;
            end else if ((in_ch.operation == spc_pkg::OP_TICK) &&
                         (run_mode == spc_pkg::MODE_DATA)) begin
              state <= S_POLL;
            end else if (scan_wanted) begin
              state <= S_SCAN;
            end else begin
              // a mode other than sync or data, or a kind that does not fit the mode
              state <= S_OUT;
            end
          end
        end

        S_POLL: begin
          pend.send_valid   <= 1'b1;
          pend.send_kind    <= everyone_ready ? spc_pkg::SK_DATA : spc_pkg::SK_START;
          // empty table polls entry zero, whose address is zero
          pend.dest_addr    <= (count == '0) ? '0 : ram_rdata;
          pend.device_index <= spc_pkg::DEV_W'(poll_index);
          poll_index        <= poll_next;
          state             <= S_OUT;
        end

        S_SCAN: begin
          if (hit || last) begin
            state <= S_OUT;
            if (run_mode == spc_pkg::MODE_SYNC) begin
              if (hit) begin
                pend.device_index <= spc_pkg::DEV_W'(scan_idx);
              end else if (table_room) begin
                count             <= count + CNT_W'(1);
                pend.device_index <= spc_pkg::DEV_W'(count);
                pend.device_count <= spc_pkg::DCNT_W'(count + CNT_W'(1));
              end
            end else if (hit) begin
              pend.device_index <= spc_pkg::DEV_W'(scan_idx);
              if (in_kind == spc_pkg::PK_STARTED) begin
                node_ready[scan_idx] <= 1'b1;
                if (all_set) begin
                  everyone_ready <= 1'b1;
                  pend.all_ready <= 1'b1;
                end
              end else begin
                pend.temp_valid  <= 1'b1;
                pend.temperature <= in_temp;
              end
            end
          end else begin
            scan_idx <= scan_nxt[IDX_W-1:0];
          end
        end

        S_OUT: begin
          if (!out_valid || out_ch.ready) begin
            out_res   <= pend;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // result word
  assign out_ch.valid        = out_valid;
  assign out_ch.send_valid   = out_res.send_valid;
  assign out_ch.send_kind    = out_res.send_kind;
  assign out_ch.dest_addr    = out_res.dest_addr;
  assign out_ch.temp_valid   = out_res.temp_valid;
  assign out_ch.device_index = out_res.device_index;
  assign out_ch.temperature  = out_res.temperature;
  assign out_ch.device_count = out_res.device_count;
  assign out_ch.all_ready    = out_res.all_ready;

  // in_op is kept for the checks below: a tick never starts a table scan
  `include "sensor_poll_coordinator_assert.svh"

  `SPC_ASSERT_IMPLY(a_count_bound, clk, rst, 1'b1, count <= CNT_W'(NODES))
  `SPC_ASSERT_IMPLY(a_poll_in_table, clk, rst, count != '0, CNT_W'(poll_index) < count)
  `SPC_ASSERT_NEXT(a_all_ready_sticky, clk, rst, everyone_ready, everyone_ready)
  `SPC_ASSERT_NEXT(a_accept_leaves_idle, clk, rst, in_acc, state != S_IDLE)
  `SPC_ASSERT_IMPLY(a_scan_is_packet, clk, rst, state == S_SCAN, in_op == spc_pkg::OP_PACKET)

endmodule
